FILE: hdl/pmss_pkg.sv
`default_nettype none

package pmss_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SPACING_W = 16;
  localparam int SIGMA_W   = 26;

  localparam int S0_W  = 42;
  localparam int S1_W  = 52;
  localparam int S2_W  = 62;
  localparam int PA_W  = S0_W + S2_W;
  localparam int DX2_W = 2 * SPACING_W;
  localparam int N_W   = PA_W + DX2_W;
  localparam int ALU_W = N_W;
  localparam int MPL_W = S2_W;
  localparam int Q_W   = 2 * SIGMA_W;
  localparam int CNT_W = $clog2(N_W);

  localparam logic [SPACING_W-1:0] SPACING_RST = SPACING_W'(256);
  localparam logic [SIGMA_W-1:0]   SIGMA_MAX   = {SIGMA_W{1'b1}};
  localparam logic [Q_W-1:0]       ROOT_TOP    = {2'b01, {(Q_W-2){1'b0}}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } pmss_in_t;

  typedef struct packed {
    logic [SIGMA_W-1:0] sigma;
    logic               empty_profile;
    logic               too_long;
  } pmss_out_t;

  typedef struct packed {
    logic add;
    logic clear;
  } pmss_acc_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/pmss_alu.sv
`default_nettype none

module pmss_alu (
  input  logic [pmss_pkg::ALU_W-1:0] a_i,
  input  logic [pmss_pkg::ALU_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [pmss_pkg::ALU_W-1:0] res_o,
  output logic                       carry_o
);
  import pmss_pkg::*;

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   full;

  assign b_op    = sub_i ? ~b_i : b_i;
  assign full    = {1'b0, a_i} + {1'b0, b_op} + (ALU_W + 1)'(sub_i);
  assign res_o   = full[ALU_W-1:0];
  assign carry_o = full[ALU_W];

endmodule

`default_nettype wire

FILE: hdl/pmss_accum.sv
`default_nettype none

module pmss_accum #(
  parameter int MAX_BINS    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pmss_pkg::pmss_acc_ctrl_t       ctrl_i,
  input  logic [pmss_pkg::SAMPLE_W-1:0]  sample_i,
  output logic [pmss_pkg::S0_W-1:0]      s0_o,
  output logic [pmss_pkg::S1_W-1:0]      s1_o,
  output logic [pmss_pkg::S2_W-1:0]      s2_o,
  output logic                           ovf_o
);
  import pmss_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS + 1);
  localparam int SQ_W  = 2 * IDX_W;
  localparam int P1_W  = IDX_W + SAMPLE_BITS;
  localparam int P2_W  = SQ_W + SAMPLE_BITS;

  logic [IDX_W-1:0]       idx_q;
  logic [SQ_W-1:0]        sq_q;
  logic [S0_W-1:0]        s0_q;
  logic [S1_W-1:0]        s1_q;
  logic [S2_W-1:0]        s2_q;
  logic                   ovf_q;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   in_range;
  logic [P1_W-1:0]        p1;
  logic [P2_W-1:0]        p2;

  assign smp      = sample_i[SAMPLE_BITS-1:0];
  assign in_range = idx_q < IDX_W'(MAX_BINS);
  assign p1       = P1_W'(idx_q) * P1_W'(smp);
  assign p2       = P2_W'(sq_q) * P2_W'(smp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sq_q  <= '0;
      s0_q  <= '0;
      s1_q  <= '0;
      s2_q  <= '0;
      ovf_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      idx_q <= '0;
      sq_q  <= '0;
      s0_q  <= '0;
      s1_q  <= '0;
      s2_q  <= '0;
      ovf_q <= 1'b0;
    end else if (ctrl_i.add) begin
      if (in_range) begin
        idx_q <= idx_q + IDX_W'(1);
        sq_q  <= sq_q + SQ_W'({idx_q, 1'b1});
        s0_q  <= s0_q + S0_W'(smp);
        s1_q  <= s1_q + S1_W'(p1);
        s2_q  <= s2_q + S2_W'(p2);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  assign s0_o  = s0_q;
  assign s1_o  = s1_q;
  assign s2_o  = s2_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

FILE: hdl/profile_second_moment_sigma.sv
// Second-moment width of a lateral dose profile. Bins stream in one per cycle
// as unsigned samples (in_ready_o high while collecting); each adds to the sum,
// the index-weighted sum and the index-squared-weighted sum. The bin marked
// last closes the profile, and the block then computes
// sigma = floor(bin_spacing * sqrt(S0*S2 - S1^2) / S0) in 1/256 mm, saturated
// to 26 bits, with empty_profile set (sigma 0) when S0 is zero and too_long set
// when bins beyond MAX_BINS were dropped. The computation runs on one shared
// 136-bit adder/subtractor: five shift-add multiplies (multipliers of at most
// 62, 52, 16, 32 and 42 bits), a clamp subtract, a 136-step restoring divide
// and a 26-step square root, during which no input is taken. The result sits
// in an output register, so the next profile may start streaming while it
// waits to be taken.
`default_nettype none

module profile_second_moment_sigma #(
  parameter int MAX_BINS    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmss_pkg::SPACING_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pmss_pkg::pmss_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pmss_pkg::pmss_out_t            out_data_o
);
  import pmss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL_A,
    ST_MUL_C,
    ST_SUB,
    ST_MUL_DX,
    ST_MUL_N,
    ST_MUL_M,
    ST_DIV,
    ST_ROOT,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic [SPACING_W-1:0] spacing_q;
  logic [ALU_W-1:0]     acc_q;
  logic [ALU_W-1:0]     mcand_q;
  logic [MPL_W-1:0]     mplier_q;
  logic [PA_W-1:0]      pa_q;
  logic [N_W-1:0]       num_q;
  logic [Q_W-1:0]       quo_q;
  logic [Q_W-1:0]       res_q;
  logic [Q_W-1:0]       bit_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 sat_q;
  logic                 zero_q;
  logic                 empty_q;
  logic                 out_valid_q;
  pmss_out_t            out_q;

  pmss_acc_ctrl_t       acc_ctrl;
  logic [S0_W-1:0]      s0;
  logic [S1_W-1:0]      s1;
  logic [S2_W-1:0]      s2;
  logic                 ovf;

  logic [ALU_W-1:0]     alu_a;
  logic [ALU_W-1:0]     alu_b;
  logic                 alu_sub;
  logic [ALU_W-1:0]     alu_res;
  logic                 alu_carry;

  logic                 in_acc;
  logic                 out_free;
  logic                 mul_done;
  logic [ALU_W-1:0]     rem_shift;
  logic [Q_W-1:0]       quo_next;
  logic [SIGMA_W-1:0]   sigma_w;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign acc_ctrl.add   = in_acc;
  assign acc_ctrl.clear = (state_q == ST_FIN) && out_free;

  pmss_accum #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .sample_i (in_data_i.sample),
    .s0_o     (s0),
    .s1_o     (s1),
    .s2_o     (s2),
    .ovf_o    (ovf)
  );

  assign rem_shift = {acc_q[ALU_W-2:0], num_q[N_W-1]};
  assign mul_done  = (mplier_q == '0);
  assign quo_next  = {quo_q[Q_W-2:0], alu_carry};
  assign sigma_w   = zero_q ? '0 : (sat_q ? SIGMA_MAX : res_q[SIGMA_W-1:0]);

  always_comb begin
    alu_a   = acc_q;
    alu_b   = mcand_q;
    alu_sub = 1'b0;
    case (state_q)
      ST_SUB: begin
        alu_a   = ALU_W'(pa_q);
        alu_b   = acc_q;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = rem_shift;
        alu_b   = mcand_q;
        alu_sub = 1'b1;
      end
      ST_ROOT: begin
        alu_a   = acc_q;
        alu_b   = ALU_W'(res_q | bit_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc_q;
        alu_b   = mcand_q;
        alu_sub = 1'b0;
      end
    endcase
  end

  pmss_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      spacing_q   <= SPACING_RST;
      acc_q       <= '0;
      mcand_q     <= '0;
      mplier_q    <= '0;
      pa_q        <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      zero_q      <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        spacing_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.last) begin
            state_q <= ST_START;
          end
        end
        ST_START: begin
          sat_q    <= 1'b0;
          acc_q    <= '0;
          mcand_q  <= ALU_W'(s0);
          mplier_q <= MPL_W'(s2);
          if (s0 == '0) begin
            zero_q  <= 1'b1;
            empty_q <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            zero_q  <= 1'b0;
            empty_q <= 1'b0;
            state_q <= ST_MUL_A;
          end
        end
        ST_MUL_A, ST_MUL_C, ST_MUL_DX, ST_MUL_N, ST_MUL_M: begin
          if (mul_done) begin
            case (state_q)
              ST_MUL_A: begin
                acc_q    <= '0;
                pa_q     <= acc_q[PA_W-1:0];
                mcand_q  <= ALU_W'(s1);
                mplier_q <= MPL_W'(s1);
                state_q  <= ST_MUL_C;
              end
              ST_MUL_C: begin
                state_q <= ST_SUB;
              end
              ST_MUL_DX: begin
                acc_q    <= '0;
                mcand_q  <= ALU_W'(pa_q);
                mplier_q <= MPL_W'(acc_q[DX2_W-1:0]);
                state_q  <= ST_MUL_N;
              end
              ST_MUL_N: begin
                acc_q    <= '0;
                num_q    <= acc_q;
                mcand_q  <= ALU_W'(s0);
                mplier_q <= MPL_W'(s0);
                state_q  <= ST_MUL_M;
              end
              default: begin
                acc_q   <= '0;
                mcand_q <= acc_q;
                quo_q   <= '0;
                cnt_q   <= CNT_W'(N_W - 1);
                state_q <= ST_DIV;
              end
            endcase
          end else begin
            if (mplier_q[0]) begin
              acc_q <= alu_res;
            end
            mcand_q  <= {mcand_q[ALU_W-2:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
          end
        end
        ST_SUB: begin
          if (!alu_carry) begin
            zero_q  <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            pa_q     <= alu_res[PA_W-1:0];
            acc_q    <= '0;
            mcand_q  <= ALU_W'(spacing_q);
            mplier_q <= MPL_W'(spacing_q);
            state_q  <= ST_MUL_DX;
          end
        end
        ST_DIV: begin
          num_q <= {num_q[N_W-2:0], 1'b0};
          quo_q <= quo_next;
          if (alu_carry && (cnt_q >= CNT_W'(Q_W))) begin
            sat_q <= 1'b1;
          end
          if (cnt_q == '0) begin
            acc_q   <= ALU_W'(quo_next);
            res_q   <= '0;
            bit_q   <= ROOT_TOP;
            state_q <= ST_ROOT;
          end else begin
            acc_q <= alu_carry ? alu_res : rem_shift;
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_ROOT: begin
          if (sat_q || (bit_q == '0)) begin
            state_q <= ST_FIN;
          end else begin
            if (alu_carry) begin
              acc_q <= alu_res;
              res_q <= (res_q >> 1) | bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_q.sigma         <= sigma_w;
            out_q.empty_profile <= empty_q;
            out_q.too_long      <= ovf;
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result request raised outside of finish step");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last) |=> (state_q == ST_START) && !in_ready_o)
    else $error("last bin did not start the width computation");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (acc_q < mcand_q))
    else $error("division remainder not below divisor");

  a_root_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> $onehot0(bit_q))
    else $error("square root trial bit not one-hot");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.empty_profile) |-> (out_q.sigma == '0))
    else $error("empty profile with nonzero width");

endmodule

`default_nettype wire

FILE: tb/sv/tb_profile_second_moment_sigma.sv
module tb_profile_second_moment_sigma;
  timeunit 1ns;
  timeprecision 1ps;

  import pmss_pkg::*;

  localparam int PROFILE_BINS  = 1024;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_BINS   = 150;
  localparam int ROOT_SPAN     = 2 * SIGMA_W;

  typedef struct {
    logic [SAMPLE_W-1:0]  sample;
    logic                 last;
    int                   rep;
    bit                   cfg;
    logic [SPACING_W-1:0] spacing;
    bit                   typed;
    pmss_out_t            want;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [SPACING_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  pmss_in_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  pmss_out_t            out_data_o;

  // profile state kept alongside the block
  logic [SPACING_W-1:0] spacing;
  logic [S0_W-1:0]      acc_sum;
  logic [S1_W-1:0]      acc_m1;
  logic [S2_W-1:0]      acc_m2;
  logic [10:0]          bin_count;
  logic                 dropped;

  pmss_out_t pending_widths[$];
  plan_row_t plan[$];
  int        mismatch_count = 0;
  int        pushes = 0;
  int        results_seen = 0;
  int        idle_cycles = 0;
  bit        in_calm = 0;
  bit        out_calm = 0;

  profile_second_moment_sigma u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_profile();
    acc_sum   = '0;
    acc_m1    = '0;
    acc_m2    = '0;
    bin_count = '0;
    dropped   = 1'b0;
  endfunction

  function automatic void fold_bin(logic [SAMPLE_W-1:0] s);
    if (bin_count < PROFILE_BINS) begin
      acc_sum   = acc_sum + S0_W'(s);
      acc_m1    = acc_m1 + S1_W'(64'(bin_count) * 64'(s));
      acc_m2    = acc_m2 + S2_W'(64'(bin_count) * 64'(bin_count) * 64'(s));
      bin_count = bin_count + 11'd1;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic pmss_out_t close_profile();
    pmss_out_t          res;
    logic [103:0]       s0s2;
    logic [103:0]       m1sq;
    logic [103:0]       spread;
    logic [135:0]       scaled;
    logic [135:0]       norm;
    logic [135:0]       quot;
    logic [SIGMA_W-1:0] root;
    logic [SIGMA_W-1:0] trial;
    logic [51:0]        sq;
    res = '0;
    res.too_long = dropped;
    if (acc_sum == '0) begin
      res.empty_profile = 1'b1;
    end else begin
      s0s2 = 104'(acc_sum) * 104'(acc_m2);
      m1sq = 104'(acc_m1) * 104'(acc_m1);
      // negative or zero variance clamps to zero
      if (s0s2 > m1sq) begin
        spread = s0s2 - m1sq;
        scaled = 136'(spread) * 136'(spacing) * 136'(spacing);
        norm   = 136'(acc_sum) * 136'(acc_sum);
        quot   = scaled / norm;
        if (quot >= (136'(1) << ROOT_SPAN)) begin
          res.sigma = SIGMA_MAX;
        end else begin
          root = '0;
          for (int b = SIGMA_W - 1; b >= 0; b--) begin
            trial = root | (SIGMA_W'(1) << b);
            sq    = 52'(trial) * 52'(trial);
            if (sq <= quot[51:0]) root = trial;
          end
          res.sigma = root;
        end
      end
    end
    clear_profile();
    return res;
  endfunction

  task automatic add_row(input logic [SAMPLE_W-1:0] sample, input logic last, input int rep,
                         input bit cfg, input logic [SPACING_W-1:0] sp, input bit typed,
                         input pmss_out_t want);
    plan_row_t row;
    row.sample  = sample;
    row.last    = last;
    row.rep     = rep;
    row.cfg     = cfg;
    row.spacing = sp;
    row.typed   = typed;
    row.want    = want;
    plan.push_back(row);
  endtask

  task automatic push_bin(input pmss_in_t item, input bit typed, input pmss_out_t want);
    int        gap;
    pmss_out_t got;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    fold_bin(item.sample);
    if (item.last) begin
      got = close_profile();
      pending_widths.push_back(typed ? want : got);
    end
    pushes++;
    if (pushes % 50 == 0) in_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic write_spacing(input logic [SPACING_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_widths.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    spacing = value;
  endtask

  // result side
  initial begin
    int        stall;
    pmss_out_t want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_widths.size() == 0) begin
        $display("%0t unexpected result sigma=%0d empty=%0b too_long=%0b", $time,
                 out_data_o.sigma, out_data_o.empty_profile, out_data_o.too_long);
        mismatch_count++;
      end else begin
        want = pending_widths.pop_front();
        if (out_data_o.sigma !== want.sigma || out_data_o.empty_profile !== want.empty_profile
            || out_data_o.too_long !== want.too_long) begin
          $display("%0t expected sigma=%0d empty=%0b too_long=%0b, got sigma=%0d empty=%0b too_long=%0b",
                   $time, want.sigma, want.empty_profile, want.too_long, out_data_o.sigma,
                   out_data_o.empty_profile, out_data_o.too_long);
          mismatch_count++;
        end
      end
      results_seen++;
      if (results_seen % 10 == 0) out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int                   random_bins;
    int                   len;
    int                   style;
    logic [SAMPLE_W-1:0]  s;
    logic [SPACING_W-1:0] sp;
    random_bins = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    spacing = SPACING_RST;
    clear_profile();

    // empty, single-bin and short multi-bin profiles
    add_row('0, 1'b1, 1, 0, '0, 1, '{SIGMA_W'(0), 1'b1, 1'b0});
    add_row('1, 1'b1, 1, 0, '0, 1, '{SIGMA_W'(0), 1'b0, 1'b0});
    add_row(32'd5, 1'b0, 1, 0, '0, 0, '0);
    add_row(32'd0, 1'b0, 1, 0, '0, 0, '0);
    add_row(32'd5, 1'b1, 1, 0, '0, 0, '0);
    add_row('1, 1'b0, 1, 0, '0, 0, '0);
    add_row('1, 1'b1, 1, 0, '0, 0, '0);
    // zero spacing
    add_row(32'd7, 1'b0, 1, 1, 16'd0, 0, '0);
    add_row(32'd0, 1'b0, 1, 0, '0, 0, '0);
    add_row(32'd9, 1'b1, 1, 0, '0, 1, '{SIGMA_W'(0), 1'b0, 1'b0});
    // widest spread at max spacing, overlong with the last bin dropped
    add_row(32'd1, 1'b0, 1, 1, 16'hFFFF, 0, '0);
    add_row(32'd0, 1'b0, PROFILE_BINS - 2, 0, '0, 0, '0);
    add_row(32'd1, 1'b0, 1, 0, '0, 0, '0);
    add_row('1, 1'b1, 1, 0, '0, 0, '0);
    // min spacing, alternating bits
    add_row(32'h5555_AAAA, 1'b0, 1, 1, 16'd1, 0, '0);
    add_row(32'hAAAA_5555, 1'b0, 1, 0, '0, 0, '0);
    add_row(32'd1, 1'b1, 1, 0, '0, 0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].cfg) write_spacing(plan[r].spacing);
      repeat (plan[r].rep) begin
        push_bin('{sample: plan[r].sample, last: plan[r].last}, plan[r].typed, plan[r].want);
      end
    end

    while (random_bins < RANDOM_BINS) begin
      case ($urandom_range(0, 5))
        0:       sp = 16'd0;
        1:       sp = 16'd1;
        2:       sp = 16'hFFFF;
        3:       sp = SPACING_RST;
        default: sp = SPACING_W'($urandom());
      endcase
      write_spacing(sp);
      repeat ($urandom_range(3, 8)) begin
        len   = $urandom_range(1, 16);
        style = $urandom_range(0, 9);
        for (int k = 0; k < len; k++) begin
          case (style)
            0, 1, 2: s = $urandom();
            3, 4:    s = $urandom_range(0, 255);
            5, 6:    s = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
            7:       s = '0;
            default: s = $urandom_range(0, 1) ? '1 : $urandom();
          endcase
          push_bin('{sample: s, last: (k == len - 1)}, 0, '0);
          random_bins++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_widths.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
